### hdl/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// Shared constants and types for the set-associative LRU cache lookup core.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int WAYS   = 4;
  localparam int SETS   = 256;
  localparam int ADDR_W = 32;
  localparam int TAG_W  = 32;
  localparam int STAMP_W = 32;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int OUT_WAY_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;
  localparam int SHIFT_W = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd1;

  localparam logic [CFG_DATA_W-1:0] OFFSET_BITS_RST = 4'd5;
  localparam logic [CFG_DATA_W-1:0] SET_BITS_RST    = 4'd8;

  // One set of the cache, held as a single memory row.
  typedef struct packed {
    logic [WAYS-1:0]              valid;
    logic [WAYS-1:0][TAG_W-1:0]   tag;
    logic [WAYS-1:0][STAMP_W-1:0] stamp;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
  } lookup_t;

endpackage

### hdl/slc_ram.sv
// ----------------------------------------------------------------------------
// slc_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module slc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/slc_way_select.sv
// ----------------------------------------------------------------------------
// slc_way_select
// Tag compare over the ways of one set, and victim choice on a miss.
// ----------------------------------------------------------------------------
module slc_way_select (
  input  slc_pkg::row_t              row,
  input  logic [slc_pkg::TAG_W-1:0]  tag,
  output slc_pkg::lookup_t           result
);
  import slc_pkg::*;

  logic               hit;
  logic [WAY_W-1:0]   hit_way;
  logic               found_free;
  logic [WAY_W-1:0]   free_way;
  logic [STAMP_W-1:0] lowest;
  logic [WAY_W-1:0]   oldest_way;

  always_comb begin
    hit = 1'b0;
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && row.valid[w] && row.tag[w] == tag) begin
        hit = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    found_free = 1'b0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found_free && !row.valid[w]) begin
        found_free = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  // Strict less-than keeps the lowest way on equal stamps.
  always_comb begin
    lowest = row.stamp[0];
    oldest_way = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (row.stamp[w] < lowest) begin
        lowest = row.stamp[w];
        oldest_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    result.hit = hit;
    if (hit) begin
      result.way = hit_way;
    end else if (found_free) begin
      result.way = free_way;
    end else begin
      result.way = oldest_way;
    end
  end

endmodule

### hdl/set_assoc_lru_cache_lookup_core.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_core
// Set-associative tag lookup with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Timing: done is registered from pend, which is set at the edge at which start
// is taken, and hit and way are registered alongside done.
// Accesses do not overlap: busy holds off start during the read-modify-write of
// the set row in the single set memory (read, then write).
// Reset: synchronous; a clearing pass then zeroes all SETS (256) rows with
// busy held high. Configuration writes are taken at any time.
module set_assoc_lru_cache_lookup_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [slc_pkg::ADDR_W-1:0]      address,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            done,
  output logic                            hit,
  output logic [slc_pkg::OUT_WAY_W-1:0]   way
);
  import slc_pkg::*;

  logic                  clearing;
  logic [SET_W-1:0]      clr_addr;
  logic                  pend;
  logic [SET_W-1:0]      req_set;
  logic [TAG_W-1:0]      req_tag;
  logic [STAMP_W-1:0]    counter;
  logic [CFG_DATA_W-1:0] offset_bits;
  logic [CFG_DATA_W-1:0] set_bits;

  logic                  accept;
  logic [ADDR_W-1:0]     shifted;
  logic [ADDR_W-1:0]     set_mask;
  logic [SET_W-1:0]      set_idx;
  logic [TAG_W-1:0]      tag;
  logic [SHIFT_W-1:0]    tag_shift;

  logic [ROW_W-1:0]      rd_data;
  logic [ROW_W-1:0]      wr_data;
  logic [SET_W-1:0]      wr_addr;
  logic                  wr_en;
  row_t                  rd_row;
  row_t                  row_next;
  lookup_t               sel;

  assign busy      = clearing | pend;
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  // Address split: the offset is shifted out and the index keeps only the
  // low set_bits bits; the tag is what lies above both fields.
  always_comb begin
    shifted   = address >> offset_bits;
    set_mask  = (ADDR_W'(1) << set_bits) - ADDR_W'(1);
    set_idx   = SET_W'(shifted & set_mask);
    tag_shift = SHIFT_W'(offset_bits) + SHIFT_W'(set_bits);
    tag       = TAG_W'(address >> tag_shift);
  end

  slc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_set_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (set_idx),
    .rdata (rd_data)
  );

  assign rd_row = row_t'(rd_data);

  slc_way_select u_way_select (
    .row    (rd_row),
    .tag    (req_tag),
    .result (sel)
  );

  always_comb begin
    row_next = rd_row;
    row_next.stamp[sel.way] = counter;
    if (!sel.hit) begin
      row_next.valid[sel.way] = 1'b1;
      row_next.tag[sel.way]   = req_tag;
    end
  end

  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = pend;
      wr_addr = req_set;
      wr_data = ROW_W'(row_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + SET_W'(1);
      if (clr_addr == SET_W'(SETS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= 1'b0;
      done    <= 1'b0;
      counter <= '0;
    end else begin
      pend <= accept;
      done <= pend;
      if (pend) begin
        counter <= counter + STAMP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_set <= set_idx;
      req_tag <= tag;
    end
    if (pend) begin
      hit <= sel.hit;
      way <= OUT_WAY_W'(sel.way);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_BITS_RST;
      set_bits    <= SET_BITS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OFFSET_BITS: offset_bits <= cfg_data;
        REG_SET_BITS:    set_bits    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### hdl/slc_checker.sv
// ----------------------------------------------------------------------------
// slc_checker
// Port-level checks on the timing of accepted accesses and result strobes.
// ----------------------------------------------------------------------------
module slc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // Every accepted access yields its strobe, registered through pend and done.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result strobe missing two cycles after an accepted access");

  // No strobe appears without a matching accepted access before it.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result strobe without a matching accepted access");

  // The block stays busy for the cycle after it takes an access.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted access");

  // Accesses are never taken back to back, so strobes never sit side by side.
  assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobes in consecutive cycles");

endmodule

bind set_assoc_lru_cache_lookup_core slc_checker u_slc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
